[design/tdps_pkg.sv]
`timescale 1ns / 1ps
package tdps_pkg;

	localparam int DEF_MAX_INTERVALS = 16;
	localparam int DEF_MAX_SECTIONS  = 16;

	localparam int HOUR_MAX      = 23;
	localparam int MINUTE_MAX    = 59;
	localparam int SECOND_MAX    = 59;
	localparam int MIN_PER_HOUR  = 60;
	localparam int MIN_PER_DAY   = 24 * 60;
	localparam int SEC_PER_MIN   = 60;

	localparam int QUEUE_DEPTH = 2;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// one stored day section: valid mark travels with the entry
	typedef struct packed {
		logic       valid;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [7:0] plan;
		logic [7:0] kind;
	} sect_t;

	localparam int SECT_W = $bits(sect_t);

	// classified word handed from front to back
	typedef struct packed {
		logic        is_query;
		logic        iv_ok;
		logic [3:0]  interval_id;
		logic [3:0]  section_index;
		sect_t       sect;
		logic [10:0] now_min;
		logic [5:0]  now_sec;
	} item_t;

	function automatic logic [10:0] to_minutes(input logic [4:0] hour, input logic [5:0] minute);
		return 11'(hour) * 11'(MIN_PER_HOUR) + 11'(minute);
	endfunction

endpackage

[design/tdps_ram.sv]
`timescale 1ns / 1ps
module tdps_ram #(
	parameter int WIDTH = 28,
	parameter int DEPTH = 256
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/tdps_front.sv]
`timescale 1ns / 1ps
module tdps_front import tdps_pkg::*; #(
	parameter int MAX_INTERVALS = DEF_MAX_INTERVALS,
	parameter int MAX_SECTIONS  = DEF_MAX_SECTIONS
) (
	input  logic       start,
	output logic       busy,
	input  logic       mode,
	input  logic [3:0] interval_id,
	input  logic [3:0] section_index,
	input  logic       entry_valid,
	input  logic [4:0] start_hour,
	input  logic [5:0] start_minute,
	input  logic [7:0] plan_number,
	input  logic [7:0] plan_kind,
	input  logic [4:0] now_hour,
	input  logic [5:0] now_minute,
	input  logic [5:0] now_second,
	input  logic       clearing,
	input  logic       q_full,
	output logic       push,
	output item_t      push_item
);

	logic       iv_ok;
	logic       sx_ok;
	logic       keep;
	logic [4:0] sh;
	logic [5:0] sm;
	logic [4:0] nh;
	logic [5:0] nm;
	logic [5:0] ns;

	// saturate time fields
	assign sh = (start_hour > 5'(HOUR_MAX)) ? 5'(HOUR_MAX) : start_hour;
	assign sm = (start_minute > 6'(MINUTE_MAX)) ? 6'(MINUTE_MAX) : start_minute;
	assign nh = (now_hour > 5'(HOUR_MAX)) ? 5'(HOUR_MAX) : now_hour;
	assign nm = (now_minute > 6'(MINUTE_MAX)) ? 6'(MINUTE_MAX) : now_minute;
	assign ns = (now_second > 6'(SECOND_MAX)) ? 6'(SECOND_MAX) : now_second;

	assign iv_ok = 32'(interval_id) < MAX_INTERVALS;
	assign sx_ok = 32'(section_index) < MAX_SECTIONS;

	// drop out-of-range writes here; queries always go on to answer
	assign keep = (mode == MODE_QUERY) || (iv_ok && sx_ok);
	assign busy = q_full || clearing;
	assign push = start && !busy && keep;

	always_comb begin
		push_item.is_query      = (mode == MODE_QUERY);
		push_item.iv_ok         = iv_ok;
		push_item.interval_id   = interval_id;
		push_item.section_index = section_index;
		push_item.sect.valid    = entry_valid;
		push_item.sect.hour     = sh;
		push_item.sect.minute   = sm;
		push_item.sect.plan     = plan_number;
		push_item.sect.kind     = plan_kind;
		push_item.now_min       = to_minutes(nh, nm);
		push_item.now_sec       = ns;
	end

endmodule

[design/tdps_queue.sv]
`timescale 1ns / 1ps
module tdps_queue import tdps_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output logic  full,
	output logic  not_empty,
	output item_t head
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	item_t         slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/tdps_back.sv]
`timescale 1ns / 1ps
module tdps_back import tdps_pkg::*; #(
	parameter int MAX_INTERVALS = DEF_MAX_INTERVALS,
	parameter int MAX_SECTIONS  = DEF_MAX_SECTIONS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	input  item_t        q_item,
	output logic         q_pop,
	output logic         clearing,
	output logic         ram_we,
	output logic [((MAX_INTERVALS * MAX_SECTIONS > 1) ?
		$clog2(MAX_INTERVALS * MAX_SECTIONS) : 1)-1:0] ram_waddr,
	output sect_t        ram_wdata,
	output logic         ram_re,
	output logic [((MAX_INTERVALS * MAX_SECTIONS > 1) ?
		$clog2(MAX_INTERVALS * MAX_SECTIONS) : 1)-1:0] ram_raddr,
	input  sect_t        ram_rdata,
	output logic         done,
	output logic         found,
	output logic [7:0]   chosen_plan,
	output logic [7:0]   chosen_kind,
	output logic [16:0]  seconds_left
);

	localparam int DEPTH = MAX_INTERVALS * MAX_SECTIONS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(MAX_SECTIONS + 1);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_SCAN  = 3'b100
	} state_t;

	state_t        state_q;
	logic [AW-1:0] clr_cnt_q;
	logic [CW-1:0] cnt_q;
	logic          pend_s1;
	logic [AW-1:0] base_q;
	logic [10:0]   now_q;
	logic [5:0]    ns_q;

	logic          past_found_q;
	logic [10:0]   past_gap_q;
	logic [7:0]    past_plan_q;
	logic [7:0]    past_kind_q;
	logic          next_found_q;
	logic [10:0]   next_gap_q;
	logic          late_found_q;
	logic [10:0]   late_start_q;
	logic [7:0]    late_plan_q;
	logic [7:0]    late_kind_q;

	logic          done_q;
	logic          found_q;
	logic [7:0]    plan_q;
	logic [7:0]    kind_q;
	logic [16:0]   secs_q;

	logic          take;
	logic          take_wr;
	logic          take_bad;
	logic          issue;
	logic          fin;
	logic [10:0]   st;
	logic          is_past;
	logic [10:0]   pgap;
	logic [10:0]   ngap;
	logic [10:0]   end_gap;
	logic [16:0]   secs_calc;
	logic          use_late;

	assign take     = (state_q == ST_IDLE) && q_valid;
	assign take_wr  = take && !q_item.is_query;
	assign take_bad = take && q_item.is_query && !q_item.iv_ok;
	assign issue    = (state_q == ST_SCAN) && (cnt_q < CW'(MAX_SECTIONS));
	assign fin      = (state_q == ST_SCAN) && !issue && !pend_s1;

	assign q_pop    = take;
	assign clearing = (state_q == ST_CLEAR);

	assign ram_we    = clearing || take_wr;
	assign ram_waddr = clearing ? clr_cnt_q
		: AW'(32'(q_item.interval_id) * MAX_SECTIONS + 32'(q_item.section_index));
	assign ram_wdata = clearing ? '0 : q_item.sect;
	assign ram_re    = issue;
	assign ram_raddr = base_q + AW'(cnt_q);

	// compare the entry read back last cycle against the running best
	assign st      = to_minutes(ram_rdata.hour, ram_rdata.minute);
	assign is_past = (now_q >= st);
	assign pgap    = now_q - st;
	assign ngap    = st - now_q;

	assign use_late  = !past_found_q || !next_found_q;
	assign end_gap   = next_found_q ? next_gap_q : 11'(MIN_PER_DAY) - now_q;
	assign secs_calc = 17'(end_gap) * 17'(SEC_PER_MIN) - 17'(ns_q);

	always_ff @(posedge clk) begin
		if (take) begin
			base_q <= AW'(32'(q_item.interval_id) * MAX_SECTIONS);
			now_q  <= q_item.now_min;
			ns_q   <= q_item.now_sec;
		end
		if (take) begin
			past_found_q <= 1'b0;
			past_gap_q   <= 11'(MIN_PER_DAY);
			next_found_q <= 1'b0;
			next_gap_q   <= 11'(MIN_PER_DAY);
			late_found_q <= 1'b0;
			late_start_q <= '0;
		end else if (pend_s1 && ram_rdata.valid) begin
			if (is_past) begin
				if (pgap <= past_gap_q) begin
					past_found_q <= 1'b1;
					past_gap_q   <= pgap;
					past_plan_q  <= ram_rdata.plan;
					past_kind_q  <= ram_rdata.kind;
				end
			end else if (ngap <= next_gap_q) begin
				next_found_q <= 1'b1;
				next_gap_q   <= ngap;
			end
			if (st >= late_start_q) begin
				late_found_q <= 1'b1;
				late_start_q <= st;
				late_plan_q  <= ram_rdata.plan;
				late_kind_q  <= ram_rdata.kind;
			end
		end
		if (take_bad) begin
			found_q <= 1'b0;
			plan_q  <= '0;
			kind_q  <= '0;
			secs_q  <= '0;
		end else if (fin) begin
			found_q <= late_found_q;
			plan_q  <= !late_found_q ? 8'd0 : (use_late ? late_plan_q : past_plan_q);
			kind_q  <= !late_found_q ? 8'd0 : (use_late ? late_kind_q : past_kind_q);
			secs_q  <= late_found_q ? secs_calc : 17'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			cnt_q     <= '0;
			pend_s1   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q  <= take_bad || fin;
			pend_s1 <= issue;
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (take && q_item.is_query && q_item.iv_ok) begin
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (fin) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign found        = found_q;
	assign chosen_plan  = plan_q;
	assign chosen_kind  = kind_q;
	assign seconds_left = secs_q;

endmodule

[design/time_of_day_plan_select_top.sv]
`timescale 1ns / 1ps
// Query: a query word with a valid interval gives its result on done once the back has read all
//   sections of its interval; the back scans one stored section per cycle through the RAM read port.
// The back takes the next queued word only when idle, after a scan ends; a write word retires when taken.
// Reset: arst_n clears control at once, then a clearing pass over all MAX_INTERVALS * MAX_SECTIONS
//   words wipes the section RAM with busy high; the receiver cannot stall done.
module time_of_day_plan_select_top import tdps_pkg::*; #(
	parameter int MAX_INTERVALS = DEF_MAX_INTERVALS,
	parameter int MAX_SECTIONS  = DEF_MAX_SECTIONS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [3:0]  interval_id,
	input  logic [3:0]  section_index,
	input  logic        entry_valid,
	input  logic [4:0]  start_hour,
	input  logic [5:0]  start_minute,
	input  logic [7:0]  plan_number,
	input  logic [7:0]  plan_kind,
	input  logic [4:0]  now_hour,
	input  logic [5:0]  now_minute,
	input  logic [5:0]  now_second,
	output logic        done,
	output logic        found,
	output logic [7:0]  chosen_plan,
	output logic [7:0]  chosen_kind,
	output logic [16:0] seconds_left
);

	localparam int DEPTH = MAX_INTERVALS * MAX_SECTIONS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// front to queue
	logic          push;
	item_t         push_item;
	logic          q_full;

	// queue to back
	logic          q_valid;
	item_t         q_head;
	logic          q_pop;
	logic          clearing;

	// section RAM: one word per (interval, section), valid mark kept in the word
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	sect_t         ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	sect_t         ram_rdata;

	// Front: saturate time fields, drop out-of-range writes, classify the word.
	tdps_front #(
		.MAX_INTERVALS (MAX_INTERVALS),
		.MAX_SECTIONS  (MAX_SECTIONS)
	) u_front (
		.start         (start),
		.busy          (busy),
		.mode          (mode),
		.interval_id   (interval_id),
		.section_index (section_index),
		.entry_valid   (entry_valid),
		.start_hour    (start_hour),
		.start_minute  (start_minute),
		.plan_number   (plan_number),
		.plan_kind     (plan_kind),
		.now_hour      (now_hour),
		.now_minute    (now_minute),
		.now_second    (now_second),
		.clearing      (clearing),
		.q_full        (q_full),
		.push          (push),
		.push_item     (push_item)
	);

	// Short queue: hold accepted words while the back is scanning.
	tdps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (q_head)
	);

	// Back: clear the RAM after reset, store writes, scan sections for queries.
	tdps_back #(
		.MAX_INTERVALS (MAX_INTERVALS),
		.MAX_SECTIONS  (MAX_SECTIONS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_head),
		.q_pop        (q_pop),
		.clearing     (clearing),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.done         (done),
		.found        (found),
		.chosen_plan  (chosen_plan),
		.chosen_kind  (chosen_kind),
		.seconds_left (seconds_left)
	);

	tdps_ram #(
		.WIDTH (SECT_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
